FILE: rtl/bapp_pkg.sv
// Shared types and constants for the advertising payload parser.
// No dependencies; the front, queue, back and top level import this package.
`default_nettype none

package bapp_pkg;

  // Width of the record length field on the input channel
  localparam int LEN_W  = 5;
  // Value index counter, saturates at all ones
  localparam int VIDX_W = 6;

  // Queue between the parse front and the result back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_MFG     = 2'd1;
  localparam logic [1:0] KIND_SVC     = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic svc;
    logic mfg;
    logic name;
    logic tx;
    logic flags;
  } marks_t;

  // One queue entry: an optional byte result, then an optional summary
  typedef struct packed {
    logic              byte_vld;
    logic [1:0]        kind;
    logic [7:0]        data;
    logic              restart;
    logic              sum_vld;
    logic [7:0]        flags_value;
    logic signed [7:0] tx_power_value;
    marks_t            marks;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: rtl/bapp_if.sv
// Channel interfaces for the advertising payload parser.
// Input channel carries payload bytes, output channel carries result items.
`default_nettype none

interface bapp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [4:0] record_len;

  modport source (output valid, data_byte, record_len, input ready);
  modport sink   (input valid, data_byte, record_len, output ready);
endinterface

interface bapp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [7:0]        out_byte;
  logic              name_restart;
  logic [7:0]        flags_value;
  logic              flags_seen;
  logic signed [7:0] tx_power_value;
  logic              tx_power_seen;
  logic              name_found;
  logic              mfg_found;
  logic              svc_found;
  logic              run_last;

  modport source (output valid, result_kind, out_byte, name_restart, flags_value,
                  flags_seen, tx_power_value, tx_power_seen, name_found,
                  mfg_found, svc_found, run_last, input ready);
  modport sink   (input valid, result_kind, out_byte, name_restart, flags_value,
                  flags_seen, tx_power_value, tx_power_seen, name_found,
                  mfg_found, svc_found, run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bapp_front.sv
// Parse front: accepts payload bytes, walks the length-type-value structures
// and pushes one queue entry per item that causes results. Uses bapp_pkg.
`default_nettype none

module bapp_front #(
  parameter int MAX_PAYLOAD   = 31,
  parameter int NAME_CHARS    = 47,
  parameter int PREVIEW_BYTES = 24
) (
  input  logic               clk,
  input  logic               rst,
  bapp_in_if.sink            in_ch,
  input  logic               q_ready,
  output logic               push,
  output bapp_pkg::q_entry_t entry
);
  import bapp_pkg::*;

  localparam int LenFull   = (1 << LEN_W) - 1;
  localparam int LenCapInt = (MAX_PAYLOAD < LenFull) ? MAX_PAYLOAD : LenFull;
  localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(LenCapInt);
  localparam logic [VIDX_W-1:0] NAME_LIM = VIDX_W'(NAME_CHARS);
  localparam logic [VIDX_W-1:0] PREV_LIM = VIDX_W'(PREVIEW_BYTES);

  localparam logic [7:0] T_FLAGS      = 8'h01;
  localparam logic [7:0] T_NAME_SHORT = 8'h08;
  localparam logic [7:0] T_NAME_FULL  = 8'h09;
  localparam logic [7:0] T_TXPOW      = 8'h0A;
  localparam logic [7:0] T_SVC16      = 8'h16;
  localparam logic [7:0] T_MFG        = 8'hFF;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;

  function automatic logic [7:0] sanitize(input logic [7:0] c);
    if (c == 8'h22 || c == 8'h5C) begin
      return CH_UNDERSCORE;
    end else if (c >= 8'h20 && c <= 8'h7E) begin
      return c;
    end
    return CH_DOT;
  endfunction

  // Record state
  logic [LEN_W-1:0]  bp;
  phase_t            phase;
  logic [7:0]        rem;
  logic [7:0]        cur_type;
  logic [VIDX_W-1:0] vidx;
  logic              cap;
  marks_t            marks;
  logic [7:0]        flags_store;
  logic [7:0]        tx_store;

  phase_t            phase_next;
  logic [7:0]        rem_next;
  logic [7:0]        cur_type_next;
  logic [VIDX_W-1:0] vidx_next;
  logic              cap_next;
  marks_t            marks_next;
  logic [7:0]        flags_store_next;
  logic [7:0]        tx_store_next;

  logic [7:0]       b;
  logic [LEN_W-1:0] len;
  logic             len_zero;
  logic             parse_en;
  logic             rec_end;
  logic             overrun;
  logic [7:0]       rem_dec;
  logic             accept;
  logic             is_name;

  assign b        = in_ch.data_byte;
  assign len      = (in_ch.record_len > LEN_CAP) ? LEN_CAP : in_ch.record_len;
  assign len_zero = (len == '0);
  assign parse_en = (bp < len);
  assign rec_end  = ({1'b0, bp} + (LEN_W+1)'(1)) >= {1'b0, len};
  assign overrun  = ({4'b0, bp} + 9'd1 + {1'b0, b}) > {4'b0, len};
  assign rem_dec  = rem - 8'd1;
  assign is_name  = (cur_type == T_NAME_SHORT) || (cur_type == T_NAME_FULL);

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  // Next state of the parse walk
  always_comb begin
    phase_next       = phase;
    rem_next         = rem;
    cur_type_next    = cur_type;
    vidx_next        = vidx;
    cap_next         = cap;
    marks_next       = marks;
    flags_store_next = flags_store;
    tx_store_next    = tx_store;
    if (parse_en) begin
      case (phase)
        PH_LEN: begin
          if (b == 8'd0 || overrun) begin
            phase_next = PH_STOP;
          end else begin
            rem_next   = b;
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          cur_type_next = b;
          rem_next      = rem_dec;
          vidx_next     = '0;
          cap_next      = 1'b0;
          if (rem_dec == 8'd0) begin
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_VALUE;
            if (b == T_NAME_FULL || (b == T_NAME_SHORT && !marks.name)) begin
              cap_next        = 1'b1;
              marks_next.name = 1'b1;
            end else if (b == T_MFG && !marks.mfg) begin
              cap_next       = 1'b1;
              marks_next.mfg = 1'b1;
            end else if (b == T_SVC16 && !marks.svc) begin
              cap_next       = 1'b1;
              marks_next.svc = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (vidx == '0 && cur_type == T_FLAGS) begin
            flags_store_next = b;
            marks_next.flags = 1'b1;
          end
          if (vidx == '0 && cur_type == T_TXPOW) begin
            tx_store_next = b;
            marks_next.tx = 1'b1;
          end
          if (vidx != '1) begin
            vidx_next = vidx + VIDX_W'(1);
          end
          rem_next = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_next = PH_LEN;
            cap_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue entry for this item
  always_comb begin
    entry = '0;
    if (parse_en && phase == PH_VALUE && cap) begin
      if (is_name) begin
        entry.byte_vld = (vidx < NAME_LIM);
        entry.kind     = KIND_NAME;
        entry.data     = sanitize(b);
        entry.restart  = (vidx == '0);
      end else begin
        entry.byte_vld = (vidx < PREV_LIM);
        entry.kind     = (cur_type == T_MFG) ? KIND_MFG : KIND_SVC;
        entry.data     = b;
      end
    end
    if (rec_end) begin
      entry.sum_vld        = 1'b1;
      entry.flags_value    = flags_store_next;
      entry.tx_power_value = tx_store_next;
      entry.marks          = marks_next;
    end
    push = accept && !len_zero && (entry.byte_vld || entry.sum_vld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp          <= '0;
      phase       <= PH_LEN;
      rem         <= '0;
      cur_type    <= '0;
      vidx        <= '0;
      cap         <= 1'b0;
      marks       <= '0;
      flags_store <= '0;
      tx_store    <= '0;
    end else if (accept && !len_zero) begin
      if (rec_end) begin
        // clear the record after its summary
        bp          <= '0;
        phase       <= PH_LEN;
        rem         <= '0;
        cur_type    <= '0;
        vidx        <= '0;
        cap         <= 1'b0;
        marks       <= '0;
        flags_store <= '0;
        tx_store    <= '0;
      end else begin
        bp          <= bp + LEN_W'(1);
        phase       <= phase_next;
        rem         <= rem_next;
        cur_type    <= cur_type_next;
        vidx        <= vidx_next;
        cap         <= cap_next;
        marks       <= marks_next;
        flags_store <= flags_store_next;
        tx_store    <= tx_store_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_summary: assert property (@(posedge clk) disable iff (rst)
    (push && entry.sum_vld) |=> (bp == '0 && marks == '0 && phase == PH_LEN))
    else $error("record state not cleared after summary");

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TYPE || phase == PH_VALUE) |-> (rem != 8'd0))
    else $error("structure walk with no bytes remaining");

  a_cap_in_value: assert property (@(posedge clk) disable iff (rst)
    cap |-> (phase == PH_VALUE))
    else $error("capture active outside a value");
`endif

endmodule

`default_nettype wire

FILE: rtl/bapp_queue.sv
// Short queue of parse entries between the front and the back.
// Uses bapp_pkg for the entry type and the depth.
`default_nettype none

module bapp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bapp_pkg::q_entry_t wr_entry,
  output logic               ready,
  input  logic               pop,
  output logic               nonempty,
  output bapp_pkg::q_entry_t head
);
  import bapp_pkg::*;

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign ready    = (count != (Q_AW+1)'(Q_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (ready || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/bapp_back.sv
// Result back: drains queue entries and emits a byte result and/or a
// record summary per entry. Uses bapp_pkg and bapp_out_if.
`default_nettype none

module bapp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  bapp_pkg::q_entry_t head,
  output logic               pop,
  bapp_out_if.source         out_ch
);
  import bapp_pkg::*;

  logic sum_phase;
  logic show_byte;
  logic out_acc;

  assign show_byte    = head.byte_vld && !sum_phase;
  assign out_ch.valid = nonempty;
  assign out_acc      = nonempty && out_ch.ready;
  // pop after the last result of the entry leaves
  assign pop          = out_acc && !(show_byte && head.sum_vld);

  always_comb begin
    out_ch.result_kind    = KIND_SUMMARY;
    out_ch.out_byte       = '0;
    out_ch.name_restart   = 1'b0;
    out_ch.flags_value    = '0;
    out_ch.flags_seen     = 1'b0;
    out_ch.tx_power_value = '0;
    out_ch.tx_power_seen  = 1'b0;
    out_ch.name_found     = 1'b0;
    out_ch.mfg_found      = 1'b0;
    out_ch.svc_found      = 1'b0;
    out_ch.run_last       = 1'b1;
    if (show_byte) begin
      out_ch.result_kind  = head.kind;
      out_ch.out_byte     = head.data;
      out_ch.name_restart = head.restart;
      out_ch.run_last     = !head.sum_vld;
    end else begin
      out_ch.flags_value    = head.flags_value;
      out_ch.flags_seen     = head.marks.flags;
      out_ch.tx_power_value = head.tx_power_value;
      out_ch.tx_power_seen  = head.marks.tx;
      out_ch.name_found     = head.marks.name;
      out_ch.mfg_found      = head.marks.mfg;
      out_ch.svc_found      = head.marks.svc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_phase <= 1'b0;
    end else if (out_acc) begin
      sum_phase <= show_byte && head.sum_vld;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ble_adv_payload_parser.sv
// Top level of the advertising payload parser: parse front, entry queue and
// result back. Depends on bapp_pkg, bapp_if, bapp_front, bapp_queue, bapp_back.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------
//   in_ch    | in  | valid/ready       | data_byte, record_len
//   out_ch   | out | valid/ready       | result_kind, out_byte, name_restart,
//            |     |                   | flags/tx_power/presence marks, run_last
//
// One payload byte is accepted per cycle while the queue is not full; its results
// go into the entry queue. An item with a byte result and a summary gives two
// results, byte first; the output drains one result per cycle while out_ch.ready
// is high, and the 4-entry queue absorbs bursts.
// Input ready drops only when the queue is full.
// Reset (rst, synchronous) clears the record walk and empties the queue.
`default_nettype none

module ble_adv_payload_parser #(
  parameter int MAX_PAYLOAD   = 31,
  parameter int NAME_CHARS    = 47,
  parameter int PREVIEW_BYTES = 24
) (
  input  logic       clk,
  input  logic       rst,
  bapp_in_if.sink    in_ch,
  bapp_out_if.source out_ch
);
  import bapp_pkg::*;

  logic     q_ready;
  logic     push;
  q_entry_t entry;
  logic     pop;
  logic     q_nonempty;
  q_entry_t head;

  bapp_front #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .NAME_CHARS    (NAME_CHARS),
    .PREVIEW_BYTES (PREVIEW_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push),
    .entry   (entry)
  );

  bapp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .ready    (q_ready),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  bapp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
